/* rtl/bclk_pkg.sv */
// Package for the binary clock: item types, codes, limits and the brightness table.
`default_nettype none
package bclk_pkg;

   typedef struct packed {
      logic       command;
      logic [2:0] button_levels;
   } req_type;

   typedef struct packed {
      logic [5:0] minute_leds;
      logic [4:0] hour_leds;
      logic [7:0] brightness_compare;
      logic       standard_mode;
      logic       sleep_request;
      logic       blink_led;
   } rsp_type;

   typedef struct packed {
      logic [7:0] inactivity_limit;
      logic [7:0] long_press_seconds;
   } cfg_type;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_BUTTONS = 1'b1;

   localparam logic REG_INACTIVITY_LIMIT   = 1'b0;
   localparam logic REG_LONG_PRESS_SECONDS = 1'b1;

   localparam logic [7:0] INACTIVITY_LIMIT_RST   = 8'd10;
   localparam logic [7:0] LONG_PRESS_SECONDS_RST = 8'd2;

   localparam logic [5:0] SECOND_LAST = 6'd59;
   localparam logic [5:0] MINUTE_LAST = 6'd59;
   localparam logic [4:0] HOUR_LAST   = 5'd23;
   localparam logic [2:0] LEVEL_LAST  = 3'd6;
   localparam logic [7:0] SAT_MAX     = 8'd255;
   localparam logic [2:0] BUTTONS_RST = 3'b111;
   localparam logic [7:0] LEVEL_RST   = 8'd254;

   function automatic logic [7:0] level_lookup(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0: val = 8'd254;
         3'd1: val = 8'd250;
         3'd2: val = 8'd240;
         3'd3: val = 8'd210;
         3'd4: val = 8'd180;
         3'd5: val = 8'd140;
         3'd6: val = 8'd80;
         3'd7: val = 8'd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

/* rtl/bclk_step.sv */
// Clock state registers and the single-pass update for one tick or button item.
`default_nettype none
module bclk_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire bclk_pkg::req_type item,
   input  wire bclk_pkg::cfg_type cfg,
   output bclk_pkg::rsp_type      result
);

   logic [5:0] sec_ff, sec_in;
   logic [5:0] min_ff, min_in;
   logic [4:0] hour_ff, hour_in;
   logic [7:0] press_ff, press_in;
   logic [7:0] idle_ff, idle_in;
   logic       mode_ff, mode_in;
   logic       sleep_ff, sleep_in;
   logic [2:0] last_ff, last_in;
   logic [2:0] lvl_idx_ff, lvl_idx_in;
   logic [7:0] lvl_val_ff, lvl_val_in;
   logic       blink_ff, blink_in;

   always_comb begin
      logic [2:0] rise;
      logic [7:0] press_inc;
      logic [7:0] idle_inc;
      logic       std;

      sec_in     = sec_ff;
      min_in     = min_ff;
      hour_in    = hour_ff;
      press_in   = press_ff;
      idle_in    = idle_ff;
      mode_in    = mode_ff;
      sleep_in   = sleep_ff;
      last_in    = last_ff;
      lvl_idx_in = lvl_idx_ff;
      lvl_val_in = lvl_val_ff;
      blink_in   = blink_ff;

      std       = mode_ff;
      rise      = ~last_ff & item.button_levels;
      press_inc = (press_ff >= bclk_pkg::SAT_MAX) ? press_ff : press_ff + 8'd1;
      idle_inc  = (idle_ff >= bclk_pkg::SAT_MAX) ? idle_ff : idle_ff + 8'd1;

      unique case (item.command)
         bclk_pkg::CMD_TICK: begin
            press_in = press_inc;
            idle_in  = idle_inc;
            if (sec_ff >= bclk_pkg::SECOND_LAST) begin
               sec_in = '0;
               if (min_ff >= bclk_pkg::MINUTE_LAST) begin
                  min_in  = '0;
                  hour_in = (hour_ff >= bclk_pkg::HOUR_LAST) ? 5'd0 : hour_ff + 5'd1;
               end else begin
                  min_in = min_ff + 6'd1;
               end
            end else begin
               sec_in = sec_ff + 6'd1;
            end
            if (!std) begin
               blink_in = ~blink_ff;
            end else if (idle_inc >= cfg.inactivity_limit) begin
               sleep_in = 1'b1;
               idle_in  = '0;
            end
         end
         bclk_pkg::CMD_BUTTONS: begin
            idle_in = '0;
            if (!rise[0]) begin
               press_in = '0;
            end else if (press_ff >= cfg.long_press_seconds) begin
               mode_in = ~mode_ff;
            end else begin
               sec_in = '0;
               if (std) begin
                  if (min_ff >= bclk_pkg::MINUTE_LAST) begin
                     min_in  = '0;
                     hour_in = (hour_ff >= bclk_pkg::HOUR_LAST) ? 5'd0 : hour_ff + 5'd1;
                  end else begin
                     min_in = min_ff + 6'd1;
                  end
               end else begin
                  min_in = (min_ff == 6'd0 || min_ff > bclk_pkg::MINUTE_LAST) ?
                           bclk_pkg::MINUTE_LAST : min_ff - 6'd1;
               end
            end
            // hour step acts on the hour left by a minute carry
            if (rise[1]) begin
               sec_in = '0;
               if (std) begin
                  hour_in = (hour_in >= bclk_pkg::HOUR_LAST) ? 5'd0 : hour_in + 5'd1;
               end else begin
                  hour_in = (hour_in == 5'd0 || hour_in > bclk_pkg::HOUR_LAST) ?
                            bclk_pkg::HOUR_LAST : hour_in - 5'd1;
               end
            end else if (rise[2]) begin
               if (std) begin
                  sleep_in = ~sleep_ff;
               end else begin
                  lvl_idx_in = (lvl_idx_ff >= bclk_pkg::LEVEL_LAST) ? 3'd0 : lvl_idx_ff + 3'd1;
                  lvl_val_in = bclk_pkg::level_lookup(lvl_idx_in);
               end
            end
            last_in = item.button_levels;
         end
      endcase

      result.minute_leds        = min_in;
      result.hour_leds          = {hour_in[0], hour_in[1], hour_in[2], hour_in[3], hour_in[4]};
      result.brightness_compare = lvl_val_in;
      result.standard_mode      = mode_in;
      result.sleep_request      = sleep_in;
      result.blink_led          = blink_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff     <= '0;
         min_ff     <= '0;
         hour_ff    <= '0;
         press_ff   <= '0;
         idle_ff    <= '0;
         mode_ff    <= 1'b1;
         sleep_ff   <= 1'b0;
         last_ff    <= bclk_pkg::BUTTONS_RST;
         lvl_idx_ff <= '0;
         lvl_val_ff <= bclk_pkg::LEVEL_RST;
         blink_ff   <= 1'b0;
      end else if (fire) begin
         sec_ff     <= sec_in;
         min_ff     <= min_in;
         hour_ff    <= hour_in;
         press_ff   <= press_in;
         idle_ff    <= idle_in;
         mode_ff    <= mode_in;
         sleep_ff   <= sleep_in;
         last_ff    <= last_in;
         lvl_idx_ff <= lvl_idx_in;
         lvl_val_ff <= lvl_val_in;
         blink_ff   <= blink_in;
      end
   end

`ifndef ASSERT_OFF
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      sec_ff <= bclk_pkg::SECOND_LAST && min_ff <= bclk_pkg::MINUTE_LAST &&
      hour_ff <= bclk_pkg::HOUR_LAST)
      else $error("time counter out of range");
   a_level_sync: assert property (@(posedge clock) disable iff (reset)
      lvl_idx_ff <= bclk_pkg::LEVEL_LAST &&
      lvl_val_ff == bclk_pkg::level_lookup(lvl_idx_ff))
      else $error("brightness value does not match level index");
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      fire && item.command == bclk_pkg::CMD_BUTTONS |=> idle_ff == 8'd0)
      else $error("button item did not clear idle count");
`endif

endmodule
`default_nettype wire

/* rtl/binary_clock_with_set_buttons.sv */
// Top level of the binary clock: input register, state update and result register.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_item (command, button_levels)
//   rsp      out        rsp_valid / rsp_ready     rsp_item (LEDs, brightness, flags)
//   csr      in         csr_write_en              csr_index, csr_wdata
//
// An accepted item waits in the input register, then the state update writes the result register.
// One item per cycle sustained while the result is not stalled.
// Synchronous reset restores time zero, standard mode and brightness 254.
// A stalled result holds the input register; req_ready drops only when both are full.
`default_nettype none
module binary_clock_with_set_buttons (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bclk_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bclk_pkg::rsp_type      rsp_item,
   input  wire logic              csr_write_en,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_wdata
);

   logic              in_valid_ff;
   bclk_pkg::req_type in_item_ff;
   logic              out_valid_ff;
   bclk_pkg::rsp_type out_item_ff;
   bclk_pkg::cfg_type cfg_ff;
   bclk_pkg::rsp_type step_result;
   logic              advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inactivity_limit   <= bclk_pkg::INACTIVITY_LIMIT_RST;
         cfg_ff.long_press_seconds <= bclk_pkg::LONG_PRESS_SECONDS_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bclk_pkg::REG_INACTIVITY_LIMIT:   cfg_ff.inactivity_limit   <= csr_wdata;
            bclk_pkg::REG_LONG_PRESS_SECONDS: cfg_ff.long_press_seconds <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_item_ff <= '0;
      end else if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   bclk_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

`ifndef ASSERT_OFF
   a_fill_out: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("pending item not moved to result register");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |=> in_valid_ff && $stable(in_item_ff))
      else $error("held item lost while result stalled");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff && out_valid_ff && rsp_ready |=> !out_valid_ff)
      else $error("result repeated after delivery");
`endif

endmodule
`default_nettype wire

/* verif/tb_binary_clock_with_set_buttons.sv */
// Testbench for the binary clock: random and directed items checked against a behavioral tracker.
module tb_binary_clock_with_set_buttons;
   timeunit 1ns;
   timeprecision 1ps;

   class clock_face_tracker;
      logic [7:0] idle_limit;
      logic [7:0] long_press;
      logic [5:0] sec;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [7:0] press_s;
      logic [7:0] idle_s;
      logic       std_mode;
      logic       sleep;
      logic [2:0] last_btn;
      logic [2:0] lvl_idx;
      logic [7:0] lvl_val;
      logic       blink;
      logic [7:0] dim_steps [8];
      bclk_pkg::rsp_type pending_faces [$];
      int         errors;
      int         checked;

      function new();
         dim_steps = '{8'd254, 8'd250, 8'd240, 8'd210, 8'd180, 8'd140, 8'd80, 8'd0};
         idle_limit = bclk_pkg::INACTIVITY_LIMIT_RST;
         long_press = bclk_pkg::LONG_PRESS_SECONDS_RST;
         sec = '0;
         minute = '0;
         hour = '0;
         press_s = '0;
         idle_s = '0;
         std_mode = 1'b1;
         sleep = 1'b0;
         last_btn = bclk_pkg::BUTTONS_RST;
         lvl_idx = '0;
         lvl_val = bclk_pkg::LEVEL_RST;
         blink = 1'b0;
         errors = 0;
         checked = 0;
      endfunction

      function void set_reg(logic idx, logic [7:0] val);
         if (idx == bclk_pkg::REG_INACTIVITY_LIMIT) idle_limit = val;
         else long_press = val;
      endfunction

      function int pending();
         return pending_faces.size();
      endfunction

      function void hour_up();
         hour = (hour == bclk_pkg::HOUR_LAST) ? 5'd0 : hour + 5'd1;
      endfunction

      function void minute_up();
         if (minute == bclk_pkg::MINUTE_LAST) begin
            minute = '0;
            hour_up();
         end else begin
            minute = minute + 6'd1;
         end
      endfunction

      function void note_item(bclk_pkg::req_type it);
         bclk_pkg::rsp_type face;
         logic [2:0] rise;
         logic       was_std;
         if (it.command == bclk_pkg::CMD_BUTTONS) begin
            rise = ~last_btn & it.button_levels;
            was_std = std_mode;
            idle_s = '0;
            if (!rise[0]) begin
               press_s = '0;
            end else if (press_s >= long_press) begin
               std_mode = ~std_mode;
            end else begin
               sec = '0;
               if (was_std) minute_up();
               else minute = (minute == 6'd0) ? bclk_pkg::MINUTE_LAST : minute - 6'd1;
            end
            if (rise[1]) begin
               sec = '0;
               if (was_std) hour_up();
               else hour = (hour == 5'd0) ? bclk_pkg::HOUR_LAST : hour - 5'd1;
            end else if (rise[2]) begin
               if (was_std) begin
                  sleep = ~sleep;
               end else begin
                  lvl_idx = (lvl_idx == bclk_pkg::LEVEL_LAST) ? 3'd0 : lvl_idx + 3'd1;
                  lvl_val = dim_steps[lvl_idx];
               end
            end
            last_btn = it.button_levels;
         end else begin
            if (press_s != bclk_pkg::SAT_MAX) press_s = press_s + 8'd1;
            if (idle_s != bclk_pkg::SAT_MAX) idle_s = idle_s + 8'd1;
            if (sec == bclk_pkg::SECOND_LAST) begin
               sec = '0;
               minute_up();
            end else begin
               sec = sec + 6'd1;
            end
            if (!std_mode) begin
               blink = ~blink;
            end else if (idle_s >= idle_limit) begin
               sleep = 1'b1;
               idle_s = '0;
            end
         end
         face.minute_leds = minute;
         for (int i = 0; i < 5; i++) face.hour_leds[4-i] = hour[i];
         face.brightness_compare = lvl_val;
         face.standard_mode = std_mode;
         face.sleep_request = sleep;
         face.blink_led = blink;
         pending_faces.push_back(face);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task cmp_field(string name, int got, int want);
         if (got != want)
            report($sformatf("item %0d %s got %0d expected %0d", checked, name, got, want));
      endtask

      task check_face(bclk_pkg::rsp_type got);
         bclk_pkg::rsp_type want;
         if (pending_faces.size() == 0) begin
            report($sformatf("unexpected item %0h", got));
         end else begin
            want = pending_faces.pop_front();
            cmp_field("minute_leds", got.minute_leds, want.minute_leds);
            cmp_field("hour_leds", got.hour_leds, want.hour_leds);
            cmp_field("brightness_compare", got.brightness_compare, want.brightness_compare);
            cmp_field("standard_mode", got.standard_mode, want.standard_mode);
            cmp_field("sleep_request", got.sleep_request, want.sleep_request);
            cmp_field("blink_led", got.blink_led, want.blink_led);
         end
         checked++;
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   bclk_pkg::req_type req_item;
   logic       rsp_valid;
   logic       rsp_ready;
   bclk_pkg::rsp_type rsp_item;
   logic       csr_write_en;
   logic       csr_index;
   logic [7:0] csr_wdata;

   logic       hold_off;
   int         send_idle_pct;
   int         recv_stall_pct;
   clock_face_tracker faces;

   binary_clock_with_set_buttons dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_item     (rsp_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) faces.check_face(rsp_item);
      if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_req(input logic cmd, input logic [2:0] levels);
      bclk_pkg::req_type it;
      it.command = cmd;
      it.button_levels = levels;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (!req_ready);
      faces.note_item(it);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_req(bclk_pkg::CMD_TICK, 3'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (faces.pending() != 0) @(posedge clock);
   endtask

   // press and release of one button, other bits random
   task automatic tap_button(input int b, input int hold);
      logic [2:0] lv;
      lv = 3'($urandom);
      lv[b] = 1'b0;
      send_req(bclk_pkg::CMD_BUTTONS, lv);
      send_ticks(hold);
      lv = 3'($urandom);
      lv[b] = 1'b1;
      send_req(bclk_pkg::CMD_BUTTONS, lv);
   endtask

   task automatic run_phase(input logic [7:0] lim, input logic [7:0] press,
                            input int sidle, input int rstall, input int n,
                            input int hold_cycles, input bit long_hold);
      int sent;
      int k;
      wait_drained();
      csr_write_en <= 1'b1;
      csr_index <= bclk_pkg::REG_INACTIVITY_LIMIT;
      csr_wdata <= lim;
      @(posedge clock);
      csr_index <= bclk_pkg::REG_LONG_PRESS_SECONDS;
      csr_wdata <= press;
      @(posedge clock);
      csr_write_en <= 1'b0;
      faces.set_reg(bclk_pkg::REG_INACTIVITY_LIMIT, lim);
      faces.set_reg(bclk_pkg::REG_LONG_PRESS_SECONDS, press);
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      if (hold_cycles > 0) begin
         fork
            begin
               hold_off <= 1'b1;
               repeat (hold_cycles) @(posedge clock);
               hold_off <= 1'b0;
            end
         join_none
      end
      sent = 0;
      if (long_hold) begin
         tap_button(0, 260);
         sent += 262;
      end
      while (sent < n) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               k = $urandom_range(1, 8);
               send_ticks(k);
               sent += k;
            end
            3: begin
               k = $urandom_range(20, 40);
               send_ticks(k);
               sent += k;
            end
            4, 5: begin
               k = $urandom_range(0, 4);
               tap_button(0, k);
               sent += k + 2;
            end
            6: begin
               k = $urandom_range(0, 2);
               tap_button(1, k);
               sent += k + 2;
            end
            7: begin
               k = $urandom_range(0, 2);
               tap_button(2, k);
               sent += k + 2;
            end
            default: begin
               send_req(bclk_pkg::CMD_BUTTONS, 3'($urandom));
               sent += 1;
            end
         endcase
      end
   endtask

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      faces = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = bclk_pkg::REG_INACTIVITY_LIMIT;
      csr_wdata = '0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // long hold of button 0 switches to experiment mode
      send_req(bclk_pkg::CMD_BUTTONS, 3'b110);
      send_ticks(3);
      send_req(bclk_pkg::CMD_BUTTONS, 3'b111);
      // all buttons released together: minute and hour step down from zero
      send_req(bclk_pkg::CMD_BUTTONS, 3'b000);
      send_req(bclk_pkg::CMD_BUTTONS, 3'b111);
      // brightness steps, blink toggles
      repeat (4) begin
         send_req(bclk_pkg::CMD_BUTTONS, 3'b011);
         send_req(bclk_pkg::CMD_BUTTONS, 3'b111);
      end
      send_ticks(2);
      // back to standard mode, then sleep toggle and hour up
      send_req(bclk_pkg::CMD_BUTTONS, 3'b110);
      send_ticks(2);
      send_req(bclk_pkg::CMD_BUTTONS, 3'b111);
      send_req(bclk_pkg::CMD_BUTTONS, 3'b011);
      send_req(bclk_pkg::CMD_BUTTONS, 3'b111);
      send_req(bclk_pkg::CMD_BUTTONS, 3'b101);
      send_req(bclk_pkg::CMD_BUTTONS, 3'b111);
      send_ticks(2);

      run_phase(8'd1, 8'd1, 0, 0, 25, 80, 1'b0);
      run_phase(8'd255, 8'd255, 46, 0, 275, 0, 1'b1);
      run_phase(8'd0, 8'd0, 0, 46, 25, 0, 1'b0);
      run_phase(8'd5, 8'd3, 10, 10, 25, 0, 1'b0);
      run_phase(bclk_pkg::INACTIVITY_LIMIT_RST, bclk_pkg::LONG_PRESS_SECONDS_RST,
                0, 0, 25, 0, 1'b0);

      wait_drained();
      repeat (10) @(posedge clock);
      if (faces.pending() != 0)
         faces.report($sformatf("%0d items never arrived", faces.pending()));
      if (faces.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/bclk_pkg.sv
rtl/bclk_step.sv
rtl/binary_clock_with_set_buttons.sv
verif/tb_binary_clock_with_set_buttons.sv
